// ===== rtl/sst_pkg.sv =====
`default_nettype none
package sst_pkg;

  // Request actions
  typedef enum logic [1:0] {
    ACT_LIST  = 2'd0,
    ACT_SUB   = 2'd1,
    ACT_UNSUB = 2'd2,
    ACT_EMIT  = 2'd3
  } action_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ENTRY    = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_DELIVERY = 2'd2,
    KIND_FULL     = 2'd3
  } kind_e;

  localparam int unsigned NameW   = 48;
  localparam int unsigned ClientW = 4;

  // At most this many results per request
  localparam int unsigned ResultCap = 16;

  typedef struct packed {
    action_e              action;
    logic [ClientW-1:0]   requester;
    logic [NameW-1:0]     signal_name;
  } req_t;

  typedef struct packed {
    kind_e                kind;
    logic [ClientW-1:0]   destination;
    logic [NameW-1:0]     name_out;
    logic                 last;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/sst_ram.sv =====
`default_nettype none
module sst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sst_front.sv =====
`default_nettype none
module sst_front #(
  parameter int unsigned NAME_BYTES = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire sst_pkg::req_t req_i,
  output logic               valid_o,
  input  wire logic          pop_i,
  output sst_pkg::req_t      req_o
);
  import sst_pkg::*;

  // Bytes below the kept ones read as zero
  localparam int unsigned DropBits = (NAME_BYTES >= 6) ? 0 : 8 * (6 - NAME_BYTES);
  localparam logic [NameW-1:0] KeepMask = {NameW{1'b1}} << DropBits;

  req_t       slot_q [2];
  logic [1:0] used_q;
  logic       head_q;
  logic       tail;
  logic       push_ok;
  logic       pop_ok;
  req_t       masked;

  assign full    = (used_q == 2'd2);
  assign valid_o = (used_q != 2'd0);
  assign req_o   = slot_q[head_q];
  assign push_ok = push && !full;
  assign pop_ok  = pop_i && valid_o;
  assign tail    = head_q ^ used_q[0];

  // Classify: mask the name to its kept bytes
  always_comb begin
    masked             = req_i;
    masked.signal_name = req_i.signal_name & KeepMask;
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[tail] <= masked;
    end
  end

  // Two-entry request queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 2'd0;
      head_q <= 1'b0;
    end else begin
      used_q <= used_q + {1'b0, push_ok} - {1'b0, pop_ok};
      head_q <= head_q ^ pop_ok;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sst_res_fifo.sv =====
`default_nettype none
module sst_res_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sst_pkg::res_t res_i,
  output logic               full_o,
  output logic               empty,
  input  wire logic          pop,
  output sst_pkg::res_t      res_o
);
  import sst_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PW    = $clog2(Depth);

  res_t          ent_q [Depth];
  logic [PW-1:0] wptr_q;
  logic [PW-1:0] rptr_q;
  logic [PW:0]   used_q;
  logic          wr;
  logic          rd;

  assign full_o = (used_q == (PW+1)'(Depth));
  assign empty  = (used_q == '0);
  assign res_o  = ent_q[rptr_q];
  assign wr     = push_i && !full_o;
  assign rd     = pop && !empty;

  // Result storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      ent_q[wptr_q] <= res_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      used_q <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + PW'(1);
      if (rd) rptr_q <= rptr_q + PW'(1);
      used_q <= used_q + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sst_engine.sv =====
`default_nettype none
module sst_engine #(
  parameter int unsigned MAX_SIGNALS = 16,
  parameter int unsigned MAX_CLIENTS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  input  wire sst_pkg::req_t req_i,
  output logic               req_pop_o,
  output logic               res_push_o,
  output sst_pkg::res_t      res_o,
  input  wire logic          res_full_i
);
  import sst_pkg::*;

  localparam int unsigned SW  = (MAX_SIGNALS > 1) ? $clog2(MAX_SIGNALS) : 1;
  localparam int unsigned SCW = $clog2(MAX_SIGNALS + 1);
  localparam int unsigned CCW = $clog2(MAX_CLIENTS + 1);
  localparam int unsigned IdDepth = MAX_SIGNALS * MAX_CLIENTS;
  localparam int unsigned AW  = (IdDepth > 1) ? $clog2(IdDepth) : 1;
  localparam int unsigned NW  = $clog2(ResultCap);

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_SORD  = 16'h0002,
    ST_SNAM  = 16'h0004,
    ST_SCMP  = 16'h0008,
    ST_ALLOC = 16'h0010,
    ST_LORD  = 16'h0020,
    ST_LNAM  = 16'h0040,
    ST_LOUT  = 16'h0080,
    ST_CNT   = 16'h0100,
    ST_IRD   = 16'h0200,
    ST_ICMP  = 16'h0400,
    ST_SHR   = 16'h0800,
    ST_SHW   = 16'h1000,
    ST_DR    = 16'h2000,
    ST_DW    = 16'h4000,
    ST_OUT   = 16'h8000
  } state_e;

  state_e         state_q, state_d;
  req_t           cur_q, cur_d;
  kind_e          kind_q, kind_d;
  logic [SCW-1:0] k_q, k_d;
  logic [SCW-1:0] count_q, count_d;
  logic [SCW-1:0] hw_q, hw_d;
  logic [CCW-1:0] j_q, j_d;
  logic [CCW-1:0] cnt_q, cnt_d;
  logic [SW-1:0]  row_q, row_d;
  logic [NW-1:0]  n_q, n_d;

  // Table order: logical position to physical row
  logic           ord_we, ord_re;
  logic [SW-1:0]  ord_wa, ord_wd, ord_ra, ord_rd;
  // Names per row
  logic           nam_we, nam_re;
  logic [SW-1:0]  nam_wa, nam_ra;
  logic [NameW-1:0] nam_wd, nam_rd;
  // Subscriber counts per row
  logic           cn_we, cn_re;
  logic [SW-1:0]  cn_wa, cn_ra;
  logic [CCW-1:0] cn_wd, cn_rd;
  // Subscriber ids, one row of MAX_CLIENTS per signal row
  logic           id_we, id_re;
  logic [AW-1:0]  id_wa, id_ra;
  logic [ClientW-1:0] id_wd, id_rd;

  logic [SW-1:0]  alloc_row;
  logic           list_last, emit_last;

  function automatic logic [AW-1:0] id_addr(logic [SW-1:0] row, logic [CCW-1:0] col);
    id_addr = AW'(row) * AW'(MAX_CLIENTS) + AW'(col);
  endfunction

  sst_ram #(.WIDTH(SW), .DEPTH(MAX_SIGNALS)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd),
    .re_i(ord_re), .raddr_i(ord_ra), .rdata_o(ord_rd)
  );
  sst_ram #(.WIDTH(NameW), .DEPTH(MAX_SIGNALS)) u_names (
    .clk_i, .we_i(nam_we), .waddr_i(nam_wa), .wdata_i(nam_wd),
    .re_i(nam_re), .raddr_i(nam_ra), .rdata_o(nam_rd)
  );
  sst_ram #(.WIDTH(CCW), .DEPTH(MAX_SIGNALS)) u_counts (
    .clk_i, .we_i(cn_we), .waddr_i(cn_wa), .wdata_i(cn_wd),
    .re_i(cn_re), .raddr_i(cn_ra), .rdata_o(cn_rd)
  );
  sst_ram #(.WIDTH(ClientW), .DEPTH(IdDepth)) u_ids (
    .clk_i, .we_i(id_we), .waddr_i(id_wa), .wdata_i(id_wd),
    .re_i(id_re), .raddr_i(id_ra), .rdata_o(id_rd)
  );

  // Below the high-water mark, the position past the end holds a freed row
  assign alloc_row = (count_q < hw_q) ? ord_rd : count_q[SW-1:0];
  assign list_last = (k_q + SCW'(1) == count_q) || (n_q == NW'(ResultCap - 1));
  assign emit_last = (j_q + CCW'(1) == cnt_q) || (n_q == NW'(ResultCap - 1));

  // Sequencer
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    kind_d  = kind_q;
    k_d     = k_q;
    count_d = count_q;
    hw_d    = hw_q;
    j_d     = j_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    n_d     = n_q;
    ord_we = 1'b0; ord_re = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = k_q[SW-1:0];
    nam_we = 1'b0; nam_re = 1'b0; nam_wa = '0; nam_wd = cur_q.signal_name; nam_ra = ord_rd;
    cn_we  = 1'b0; cn_re  = 1'b0; cn_wa = row_q; cn_wd = '0; cn_ra = row_q;
    id_we  = 1'b0; id_re  = 1'b0; id_wa = id_addr(row_q, j_q); id_wd = cur_q.requester;
    id_ra  = id_addr(row_q, j_q);
    req_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.kind        = KIND_ENTRY;
    res_o.destination = cur_q.requester;
    res_o.name_out    = cur_q.signal_name;
    res_o.last        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          cur_d     = req_i;
          k_d       = '0;
          n_d       = '0;
          if (req_i.action == ACT_LIST) begin
            if (count_q == '0) begin
              kind_d  = KIND_EMPTY;
              state_d = ST_OUT;
            end else begin
              state_d = ST_LORD;
            end
          end else begin
            state_d = ST_SORD;
          end
        end
      end
      // Search the table for the name
      ST_SORD: begin
        if (k_q == count_q) begin
          if (cur_q.action == ACT_SUB) begin
            if (count_q == SCW'(MAX_SIGNALS)) begin
              kind_d  = KIND_FULL;
              state_d = ST_OUT;
            end else begin
              ord_re  = 1'b1;
              state_d = ST_ALLOC;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          ord_re  = 1'b1;
          state_d = ST_SNAM;
        end
      end
      ST_SNAM: begin
        nam_re  = 1'b1;
        row_d   = ord_rd;
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        if (nam_rd == cur_q.signal_name) begin
          cn_re   = 1'b1;
          state_d = ST_CNT;
        end else begin
          k_d     = k_q + SCW'(1);
          state_d = ST_SORD;
        end
      end
      // New signal at the end of the table
      ST_ALLOC: begin
        ord_we = 1'b1;
        ord_wa = count_q[SW-1:0];
        ord_wd = alloc_row;
        nam_we = 1'b1;
        nam_wa = alloc_row;
        id_we  = 1'b1;
        id_wa  = id_addr(alloc_row, '0);
        cn_we  = 1'b1;
        cn_wa  = alloc_row;
        cn_wd  = CCW'(1);
        count_d = count_q + SCW'(1);
        if (!(count_q < hw_q)) hw_d = hw_q + SCW'(1);
        state_d = ST_IDLE;
      end
      // List walk
      ST_LORD: begin
        ord_re  = 1'b1;
        state_d = ST_LNAM;
      end
      ST_LNAM: begin
        nam_re  = 1'b1;
        state_d = ST_LOUT;
      end
      ST_LOUT: begin
        res_push_o     = 1'b1;
        res_o.kind     = KIND_ENTRY;
        res_o.name_out = nam_rd;
        res_o.last     = list_last;
        if (!res_full_i) begin
          if (list_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + SCW'(1);
            n_d     = n_q + NW'(1);
            state_d = ST_LORD;
          end
        end
      end
      ST_CNT: begin
        cnt_d   = cn_rd;
        j_d     = '0;
        state_d = ST_IRD;
      end
      // Subscriber list walk
      ST_IRD: begin
        if (j_q == cnt_q) begin
          case (cur_q.action)
            ACT_SUB: begin
              if (cnt_q == CCW'(MAX_CLIENTS)) begin
                kind_d  = KIND_FULL;
                state_d = ST_OUT;
              end else begin
                id_we   = 1'b1;
                cn_we   = 1'b1;
                cn_wd   = cnt_q + CCW'(1);
                state_d = ST_IDLE;
              end
            end
            ACT_UNSUB: begin
              state_d = (cnt_q == '0) ? ST_DR : ST_IDLE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end else begin
          id_re   = 1'b1;
          state_d = ST_ICMP;
        end
      end
      ST_ICMP: begin
        case (cur_q.action)
          ACT_SUB: begin
            if (id_rd == cur_q.requester) begin
              state_d = ST_IDLE;
            end else begin
              j_d     = j_q + CCW'(1);
              state_d = ST_IRD;
            end
          end
          ACT_UNSUB: begin
            if (id_rd == cur_q.requester) begin
              cnt_d   = cnt_q - CCW'(1);
              cn_we   = 1'b1;
              cn_wd   = cnt_q - CCW'(1);
              state_d = ST_SHR;
            end else begin
              j_d     = j_q + CCW'(1);
              state_d = ST_IRD;
            end
          end
          ACT_EMIT: begin
            res_push_o        = 1'b1;
            res_o.kind        = KIND_DELIVERY;
            res_o.destination = id_rd;
            res_o.last        = emit_last;
            if (!res_full_i) begin
              if (emit_last) begin
                state_d = ST_IDLE;
              end else begin
                j_d     = j_q + CCW'(1);
                n_d     = n_q + NW'(1);
                state_d = ST_IRD;
              end
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      // Close the gap in the subscriber list
      ST_SHR: begin
        if (j_q == cnt_q) begin
          state_d = (cnt_q == '0) ? ST_DR : ST_IDLE;
        end else begin
          id_re   = 1'b1;
          id_ra   = id_addr(row_q, j_q + CCW'(1));
          state_d = ST_SHW;
        end
      end
      ST_SHW: begin
        id_we   = 1'b1;
        id_wd   = id_rd;
        j_d     = j_q + CCW'(1);
        state_d = ST_SHR;
      end
      // Delete the signal: shift the order down, freed row goes past the end
      ST_DR: begin
        if (k_q + SCW'(1) == count_q) begin
          ord_we  = 1'b1;
          ord_wa  = k_q[SW-1:0];
          ord_wd  = row_q;
          count_d = count_q - SCW'(1);
          state_d = ST_IDLE;
        end else begin
          ord_re  = 1'b1;
          ord_ra  = SW'(k_q + SCW'(1));
          state_d = ST_DW;
        end
      end
      ST_DW: begin
        ord_we  = 1'b1;
        ord_wa  = k_q[SW-1:0];
        ord_wd  = ord_rd;
        k_d     = k_q + SCW'(1);
        state_d = ST_DR;
      end
      // Single-result requests: empty list or refused subscribe
      ST_OUT: begin
        res_push_o     = 1'b1;
        res_o.kind     = kind_q;
        res_o.name_out = (kind_q == KIND_EMPTY) ? '0 : cur_q.signal_name;
        res_o.last     = 1'b1;
        if (!res_full_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      hw_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      hw_q    <= hw_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    kind_q <= kind_d;
    k_q    <= k_d;
    j_q    <= j_d;
    cnt_q  <= cnt_d;
    row_q  <= row_d;
    n_q    <= n_d;
  end

endmodule
`default_nettype wire

// ===== rtl/signal_subscription_table.sv =====
// Signal subscription table.
// Requests enter through a queue port: drive req_i and push; a request is
// taken on a clock edge with push high and full low. Results leave through
// a queue port: while empty is low, res_o holds the oldest result, and pop
// takes it. The final result of a request carries last.
// A two-entry front queue masks names and holds requests; a sequencer walks
// the order, name, count and subscriber memories one entry at a time; a
// four-entry result queue sits at the output.
// A request's run time grows with the table entries searched, the
// subscribers scanned, the subscribers moved on unsubscribe and the table
// entries moved when a signal is deleted; a list grows with its entries and
// an emit with its deliveries, all paced by the registered memory reads.
// Reset empties the table at once; no clearing pass is needed.
// When the receiver stalls, the sequencer waits on the full result queue and
// the front queue keeps taking up to two requests.
`default_nettype none
module signal_subscription_table #(
  parameter int unsigned MAX_SIGNALS = 16,
  parameter int unsigned MAX_CLIENTS = 16,
  parameter int unsigned NAME_BYTES  = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire sst_pkg::req_t req_i,
  output logic               empty,
  input  wire logic          pop,
  output sst_pkg::res_t      res_o
);
  import sst_pkg::*;

  logic req_valid;
  logic req_pop;
  req_t req_item;
  logic res_push;
  logic res_full;
  res_t res_item;

  sst_front #(.NAME_BYTES(NAME_BYTES)) u_front (
    .clk_i, .rst_ni, .push, .full, .req_i,
    .valid_o(req_valid), .pop_i(req_pop), .req_o(req_item)
  );

  sst_engine #(.MAX_SIGNALS(MAX_SIGNALS), .MAX_CLIENTS(MAX_CLIENTS)) u_engine (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_i(req_item), .req_pop_o(req_pop),
    .res_push_o(res_push), .res_o(res_item), .res_full_i(res_full)
  );

  sst_res_fifo u_res_fifo (
    .clk_i, .rst_ni,
    .push_i(res_push), .res_i(res_item), .full_o(res_full),
    .empty, .pop, .res_o
  );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import sst_pkg::*;

  localparam int unsigned NumSignals = 16;
  localparam int unsigned NumClients = 16;
  localparam int unsigned IdleLimit  = 20000;

  // Mirror of the subscription table; predicts results per request
  class sub_table_board;
    logic [NameW-1:0]   names [NumSignals];
    logic [ClientW-1:0] subs  [NumSignals][NumClients];
    int unsigned        counts[NumSignals];
    int unsigned        sig_count;
    res_t               pending[$];
    int unsigned        errors;

    function new();
      sig_count = 0;
      errors    = 0;
    endfunction

    function int lookup(logic [NameW-1:0] nm);
      for (int k = 0; k < sig_count; k++) begin
        if (names[k] == nm) return k;
      end
      return -1;
    endfunction

    function void add_result(kind_e kd, logic [ClientW-1:0] dst, logic [NameW-1:0] nm,
                             bit fin);
      res_t r;
      r.kind        = kd;
      r.destination = dst;
      r.name_out    = nm;
      r.last        = fin;
      pending.insert(pending.size(), r);
    endfunction

    function void note_request(req_t rq);
      int s;
      int unsigned cnt;
      bit hit;
      if (rq.action == ACT_LIST) begin
        if (sig_count == 0) add_result(KIND_EMPTY, rq.requester, '0, 1'b1);
        for (int k = 0; k < sig_count; k++)
          add_result(KIND_ENTRY, rq.requester, names[k], k == sig_count - 1);
        return;
      end
      s = lookup(rq.signal_name);
      case (rq.action)
        ACT_SUB: begin
          if (s < 0) begin
            if (sig_count >= NumSignals) begin
              add_result(KIND_FULL, rq.requester, rq.signal_name, 1'b1);
            end else begin
              names[sig_count]   = rq.signal_name;
              subs[sig_count][0] = rq.requester;
              counts[sig_count]  = 1;
              sig_count++;
            end
          end else begin
            hit = 0;
            for (int k = 0; k < counts[s]; k++) if (subs[s][k] == rq.requester) hit = 1;
            if (!hit) begin
              if (counts[s] >= NumClients) begin
                add_result(KIND_FULL, rq.requester, rq.signal_name, 1'b1);
              end else begin
                subs[s][counts[s]] = rq.requester;
                counts[s]++;
              end
            end
          end
        end
        ACT_UNSUB: begin
          if (s >= 0) begin
            cnt = counts[s];
            for (int k = 0; k < cnt; k++) begin
              if (subs[s][k] == rq.requester) begin
                for (int j = k; j < cnt - 1; j++) subs[s][j] = subs[s][j+1];
                cnt--;
                counts[s] = cnt;
                break;
              end
            end
            if (cnt == 0) begin
              for (int j = s; j < sig_count - 1; j++) begin
                names[j]  = names[j+1];
                counts[j] = counts[j+1];
                subs[j]   = subs[j+1];
              end
              sig_count--;
            end
          end
        end
        default: begin
          if (s >= 0) begin
            for (int k = 0; k < counts[s]; k++)
              add_result(KIND_DELIVERY, subs[s][k], names[s], k == counts[s] - 1);
          end
        end
      endcase
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind != exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind); errors++;
      end
      if (got.destination != exp.destination) begin
        $error("destination: expected %0d, got %0d", exp.destination, got.destination);
        errors++;
      end
      if (got.name_out != exp.name_out) begin
        $error("name_out: expected %h, got %h", exp.name_out, got.name_out); errors++;
      end
      if (got.last != exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, push, full, empty, pop;
  req_t req_i;
  res_t res_o;
  sub_table_board board;
  int unsigned idle_cycles;

  signal_subscription_table uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .req_i(req_i),
    .empty(empty), .pop(pop), .res_o(res_o)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Small name pool so requests collide with existing signals
  logic [NameW-1:0] name_pool[20];

  function automatic logic [NameW-1:0] rand_name();
    return NameW'({$urandom, $urandom});
  endfunction

  // Send one request, holding push until it is taken
  task automatic send(action_e act, logic [ClientW-1:0] who, logic [NameW-1:0] nm);
    req_t rq;
    rq.action      = act;
    rq.requester   = who;
    rq.signal_name = nm;
    push  <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_request(rq);
  endtask

  task automatic pause_send();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Receiver: stalls on its own pattern, with quiet stretches
  initial begin
    int unsigned phase;
    pop = 0;
    phase = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) board.check_result(res_o);
      phase++;
      if (phase % 400 < 100) pop <= 1'b1;
      else pop <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
    end
  end

  // Watchdog on cycles with no accepted request or result
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned burst;
    int unsigned r;
    board = new();
    push  = 0;
    req_i = '0;
    rst_ni = 0;
    for (int i = 0; i < 20; i++) name_pool[i] = rand_name();
    name_pool[0] = '0;
    name_pool[1] = 48'hFFFF_FFFF_FFFF;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, extremes, duplicates, unknowns, full list, full table
    send(ACT_LIST, 4'd0, '0);
    send(ACT_EMIT, 4'd3, name_pool[1]);
    send(ACT_UNSUB, 4'd3, name_pool[1]);
    send(ACT_SUB, 4'd15, name_pool[1]);
    send(ACT_SUB, 4'd15, name_pool[1]);
    send(ACT_SUB, 4'd0, name_pool[0]);
    send(ACT_UNSUB, 4'd7, name_pool[1]);
    send(ACT_EMIT, 4'd1, name_pool[1]);
    send(ACT_LIST, 4'd15, name_pool[1]);
    for (int c = 0; c < 16; c++) send(ACT_SUB, c[3:0], name_pool[2]);
    drain();
    send(ACT_EMIT, 4'd9, name_pool[2]);
    send(ACT_UNSUB, 4'd15, name_pool[1]);
    send(ACT_UNSUB, 4'd5, name_pool[2]);
    send(ACT_SUB, 4'd4, name_pool[2]);
    drain();
    for (int k = 3; k < 19; k++) send(ACT_SUB, 4'd2, name_pool[k]);
    send(ACT_LIST, 4'd8, '0);
    send(ACT_UNSUB, 4'd0, name_pool[0]);
    send(ACT_EMIT, 4'd2, name_pool[2]);
    drain();

    // Random: mostly pool names, some fresh names, bursts with gaps
    r = 0;
    while (r < 120) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        action_e act;
        logic [NameW-1:0] nm;
        act = action_e'($urandom_range(0, 3));
        nm  = ($urandom_range(0, 9) == 0) ? rand_name() : name_pool[$urandom_range(0, 19)];
        if ($urandom_range(0, 5) == 0) act = ACT_UNSUB;
        send(act, 4'($urandom_range(0, 15)), nm);
        r++;
      end
      if (r % 60 < 12) drain();
      else repeat ($urandom_range(0, 30)) pause_send();
    end
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
